// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/fpbc_pkg.sv
// ----------------------------------------------------------------------------
// fpbc_pkg
// Types, codes and constants of the IPv4 flow packet/byte counter.
// ----------------------------------------------------------------------------
package fpbc_pkg;

    localparam int FLOW_ENTRIES_DEF = 1024;
    localparam int PROBE_LIMIT_DEF  = 8;

    localparam logic [5:0] LINK_HDR_RESET = 6'd14;
    localparam logic [6:0] POS_MAX        = 7'd127;
    localparam logic [3:0] IPV4_VERSION   = 4'd4;
    localparam logic [7:0] PROTO_TCP      = 8'd6;
    localparam logic [7:0] PROTO_UDP      = 8'd17;
    localparam logic [7:0] OFS_PROTO      = 8'd9;
    localparam logic [7:0] OFS_ADDR_FIRST = 8'd12;
    localparam logic [7:0] OFS_ADDR_LAST  = 8'd19;
    localparam logic [7:0] IPV4_MIN_HDR   = 8'd20;
    localparam logic [7:0] PORT_BYTES     = 8'd4;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [2:0] STAT_EXIST   = 3'd0;
    localparam logic [2:0] STAT_NEW     = 3'd1;
    localparam logic [2:0] STAT_IGNORED = 3'd2;
    localparam logic [2:0] STAT_TRUNC   = 3'd3;
    localparam logic [2:0] STAT_FULL    = 3'd4;
    localparam logic [2:0] STAT_READ    = 3'd5;

    localparam logic [2:0] REQ_NONE   = 3'd0;
    localparam logic [2:0] REQ_IGNORE = 3'd1;
    localparam logic [2:0] REQ_TRUNC  = 3'd2;
    localparam logic [2:0] REQ_LOOKUP = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] wire_length;
        logic [9:0]  entry_index;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  flow_index;
        logic        entry_valid;
        logic [31:0] source_address;
        logic [15:0] source_port;
        logic [31:0] dest_address;
        logic [15:0] dest_port;
        logic [63:0] packet_total;
        logic [63:0] byte_total;
    } out_t;

    // parser to table request
    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] addrs;
        logic [31:0] ports;
        logic [15:0] wlen;
        logic [9:0]  index;
    } req_t;

    typedef struct packed {
        logic        used;
        logic [63:0] addrs;
        logic [31:0] ports;
        logic [63:0] packets;
        logic [63:0] bytes;
    } ent_t;

endpackage

// File: rtl/core/fpbc_parser.sv
// ----------------------------------------------------------------------------
// fpbc_parser
// Byte-wise IPv4 header parser; forms one table request per item.
// ----------------------------------------------------------------------------
module fpbc_parser
    import fpbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [5:0] cfg_data,
    input  logic       accept,
    input  in_t        item,
    output req_t       req
);

    logic [5:0]  lhb_reg;
    logic [6:0]  pos_reg,   pos_next;
    logic [3:0]  ver_reg,   ver_next;
    logic [3:0]  hw_reg,    hw_next;
    logic [7:0]  proto_reg, proto_next;
    logic [63:0] addr_reg,  addr_next;
    logic [31:0] ports_reg, ports_next;

    logic [7:0] p8, l8, pstart, need, count;
    logic       bad;

    always_comb
    begin
        p8 = {1'b0, pos_reg};
        l8 = {2'b00, lhb_reg};
        ver_next   = (p8 == l8) ? item.data_byte[7:4] : ver_reg;
        hw_next    = (p8 == l8) ? item.data_byte[3:0] : hw_reg;
        proto_next = (p8 == l8 + OFS_PROTO) ? item.data_byte : proto_reg;
        addr_next  = (p8 >= l8 + OFS_ADDR_FIRST && p8 <= l8 + OFS_ADDR_LAST) ?
                     {addr_reg[55:0], item.data_byte} : addr_reg;
        pstart     = l8 + {2'b00, hw_next, 2'b00};
        ports_next = (p8 >= pstart && p8 <= pstart + 8'd3) ?
                     {ports_reg[23:0], item.data_byte} : ports_reg;
        pos_next   = (pos_reg < POS_MAX) ? pos_reg + 7'd1 : pos_reg;
        count      = {1'b0, pos_next};
        need       = pstart + PORT_BYTES;
        if (need < l8 + IPV4_MIN_HDR)
        begin
            need = l8 + IPV4_MIN_HDR;
        end
        bad = (count > l8 && ver_next != IPV4_VERSION) ||
              (count > l8 + OFS_PROTO && proto_next != PROTO_TCP &&
               proto_next != PROTO_UDP);

        req       = '0;
        req.addrs = addr_next;
        req.ports = ports_next;
        req.wlen  = item.wire_length;
        req.index = item.entry_index;
        if (item.kind == KIND_READ)
        begin
            req.op = REQ_READ;
        end
        else if (!item.last_byte)
        begin
            req.op = REQ_NONE;
        end
        else if (bad)
        begin
            req.op = REQ_IGNORE;
        end
        else if (count < need)
        begin
            req.op = REQ_TRUNC;
        end
        else
        begin
            req.op = REQ_LOOKUP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lhb_reg   <= LINK_HDR_RESET;
            pos_reg   <= '0;
            ver_reg   <= '0;
            hw_reg    <= '0;
            proto_reg <= '0;
            addr_reg  <= '0;
            ports_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                lhb_reg <= cfg_data;
            end
            if (accept && item.kind == KIND_BYTE)
            begin
                if (item.last_byte)
                begin
                    pos_reg   <= '0;
                    ver_reg   <= '0;
                    hw_reg    <= '0;
                    proto_reg <= '0;
                    addr_reg  <= '0;
                    ports_reg <= '0;
                end
                else
                begin
                    pos_reg   <= pos_next;
                    ver_reg   <= ver_next;
                    hw_reg    <= hw_next;
                    proto_reg <= proto_next;
                    addr_reg  <= addr_next;
                    ports_reg <= ports_next;
                end
            end
        end
    end

endmodule

// File: rtl/core/fpbc_table.sv
// ----------------------------------------------------------------------------
// fpbc_table
// Hashed flow table in one synchronous memory, linear probe sequencer,
// saturating counter update and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fpbc_table
    import fpbc_pkg::*;
#(
    parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF,
    parameter int PROBE_LIMIT  = PROBE_LIMIT_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  req_t req,
    output logic idle,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam int AW = $clog2(FLOW_ENTRIES);
    localparam int HW = $clog2(FLOW_ENTRIES + 1) - 1;
    localparam int PW = $clog2(PROBE_LIMIT + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_RDOUT = 3'd4;

    ent_t mem [FLOW_ENTRIES];
    ent_t rd_q;

    logic [2:0]    state_reg, state_next;
    logic [AW:0]   clr_reg;
    logic [AW-1:0] slot_reg, slot_next, home_reg, hash_slot;
    logic [PW-1:0] probe_reg;
    logic [63:0]   key_addr_reg;
    logic [31:0]   key_port_reg;
    logic [15:0]   wlen_reg;
    logic [9:0]    ridx_reg;
    logic          rinr_reg;
    logic          out_valid_reg;
    out_t          out_reg;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    ent_t          wr_data;
    logic [HW-1:0] h;
    logic [95:0]   key;
    logic          hit;
    logic [64:0]   bsum;
    logic [63:0]   pk_new, by_new;
    logic [AW:0]   slot_inc;

    assign idle      = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        key = {key_addr_reg, key_port_reg};
        h   = '0;
        for (int b = 0; b < 96; b++)
        begin
            h[b % HW] = h[b % HW] ^ key[b];
        end
        hash_slot = AW'(h);
        slot_inc  = {1'b0, slot_reg} + 1'b1;
        slot_next = (slot_inc == (AW+1)'(FLOW_ENTRIES)) ? '0 : slot_inc[AW-1:0];
        hit       = ({rd_q.addrs, rd_q.ports} == key);
        pk_new    = (rd_q.packets == '1) ? rd_q.packets : rd_q.packets + 64'd1;
        bsum      = {1'b0, rd_q.bytes} + {49'd0, wlen_reg};
        by_new    = bsum[64] ? '1 : bsum[63:0];
    end

    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        rd_addr    = slot_reg;
        wr_en      = 1'b0;
        wr_addr    = slot_reg;
        wr_data    = '0;
        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg[AW-1:0];
                if (clr_reg == (AW+1)'(FLOW_ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && req.op == REQ_LOOKUP)
                begin
                    state_next = S_HASH;
                end
                else if (accept && req.op == REQ_READ)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(req.index);
                    state_next = S_RDOUT;
                end
            end
            S_HASH:
            begin
                rd_en      = 1'b1;
                rd_addr    = hash_slot;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!rd_q.used)
                begin
                    wr_en      = 1'b1;
                    wr_data    = {1'b1, key_addr_reg, key_port_reg, 64'd1,
                                  {48'd0, wlen_reg}};
                    state_next = S_IDLE;
                end
                else if (hit)
                begin
                    wr_en      = 1'b1;
                    wr_data    = {1'b1, key_addr_reg, key_port_reg, pk_new, by_new};
                    state_next = S_IDLE;
                end
                else if (probe_reg == PW'(PROBE_LIMIT - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = slot_next;
                end
            end
            S_RDOUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept)
        begin
            key_addr_reg <= req.addrs;
            key_port_reg <= req.ports;
            wlen_reg     <= req.wlen;
            ridx_reg     <= req.index;
            rinr_reg     <= (32'(req.index) < 32'(FLOW_ENTRIES));
        end
        if (state_reg == S_HASH)
        begin
            home_reg <= hash_slot;
            slot_reg <= hash_slot;
        end
        else if (state_reg == S_CHECK)
        begin
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            probe_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == S_HASH)
            begin
                probe_reg <= '0;
            end
            else if (state_reg == S_CHECK)
            begin
                probe_reg <= probe_reg + 1'b1;
            end
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_IDLE && accept &&
                (req.op == REQ_IGNORE || req.op == REQ_TRUNC))
            begin
                out_valid_reg <= 1'b1;
            end
            if (state_reg == S_RDOUT ||
                (state_reg == S_CHECK && state_next == S_IDLE))
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept)
        begin
            out_reg        <= '0;
            out_reg.status <= (req.op == REQ_IGNORE) ? STAT_IGNORED : STAT_TRUNC;
        end
        else if (state_reg == S_RDOUT)
        begin
            out_reg            <= '0;
            out_reg.status     <= STAT_READ;
            out_reg.flow_index <= ridx_reg;
            if (rinr_reg && rd_q.used)
            begin
                out_reg.entry_valid    <= 1'b1;
                out_reg.source_address <= rd_q.addrs[63:32];
                out_reg.dest_address   <= rd_q.addrs[31:0];
                out_reg.source_port    <= rd_q.ports[31:16];
                out_reg.dest_port      <= rd_q.ports[15:0];
                out_reg.packet_total   <= rd_q.packets;
                out_reg.byte_total     <= rd_q.bytes;
            end
        end
        else if (state_reg == S_CHECK && state_next == S_IDLE)
        begin
            out_reg.source_address <= key_addr_reg[63:32];
            out_reg.dest_address   <= key_addr_reg[31:0];
            out_reg.source_port    <= key_port_reg[31:16];
            out_reg.dest_port      <= key_port_reg[15:0];
            if (!rd_q.used)
            begin
                out_reg.status       <= STAT_NEW;
                out_reg.flow_index   <= 10'(slot_reg);
                out_reg.entry_valid  <= 1'b1;
                out_reg.packet_total <= 64'd1;
                out_reg.byte_total   <= {48'd0, wlen_reg};
            end
            else if (hit)
            begin
                out_reg.status       <= STAT_EXIST;
                out_reg.flow_index   <= 10'(slot_reg);
                out_reg.entry_valid  <= 1'b1;
                out_reg.packet_total <= pk_new;
                out_reg.byte_total   <= by_new;
            end
            else
            begin
                out_reg.status       <= STAT_FULL;
                out_reg.flow_index   <= 10'(home_reg);
                out_reg.entry_valid  <= 1'b0;
                out_reg.packet_total <= '0;
                out_reg.byte_total   <= '0;
            end
        end
    end

    `ASSERT_IMPL(a_wr_state, wr_en, state_reg == S_CLEAR || state_reg == S_CHECK)
    `ASSERT_IMPL(a_probe_bound, state_reg == S_CHECK, probe_reg < PW'(PROBE_LIMIT))
    `ASSERT_IMPL(a_accept_idle, accept, state_reg == S_IDLE)
    `ASSERT_NEXT(a_check_done, state_reg == S_CHECK && state_next == S_IDLE, out_valid_reg)

endmodule

// File: rtl/core/ipv4_flow_packet_byte_counter.sv
// ----------------------------------------------------------------------------
// ipv4_flow_packet_byte_counter
// Per-flow packet and byte counter for IPv4 TCP/UDP traffic.
//
// channel  | signals                         | carries
// ---------+---------------------------------+------------------------------
// in       | in_valid, in_ready, in_data     | packet byte or entry read
// out      | out_valid, out_ready, out_data  | one result per packet or read
// cfg      | cfg_write, cfg_data             | link header length
//
// A packet byte without end mark leaves the table idle; a read passes S_RDOUT.
// An end-of-packet lookup passes S_HASH, then S_CHECK once per probe (up to
// PROBE_LIMIT probes), as the flow table memory read is registered.
// After reset every table entry is swept clear while in_ready is low.
// in_ready also waits while a result sits in the output register untaken.
// ----------------------------------------------------------------------------
module ipv4_flow_packet_byte_counter
    import fpbc_pkg::*;
#(
    parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF,
    parameter int PROBE_LIMIT  = PROBE_LIMIT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_t       out_data,
    input  logic       cfg_write,
    input  logic [5:0] cfg_data
);

    logic idle;
    logic accept;
    req_t req;

    assign in_ready = idle && (!out_valid || out_ready);
    assign accept   = in_valid && in_ready;

    fpbc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (in_data),
        .req       (req)
    );

    fpbc_table #(
        .FLOW_ENTRIES (FLOW_ENTRIES),
        .PROBE_LIMIT  (PROBE_LIMIT)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .idle      (idle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
